>>> src/sha256_stream_hasher_top_assert.svh
// Assertion macros shared by the checker
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/sha_pkg.sv
`default_nettype none
package sha_pkg;

    localparam int unsigned NumRounds = 64;

    typedef logic [31:0] t_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_DIGEST,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       absorb;      // write input byte to buffer, count it
        logic       init_chain;  // load initial words, clear counts
        logic       start_comp;  // copy chain to working words
        logic       round;       // one compression round
        logic       add_chain;   // fold working words into chain
        logic       pad_byte;    // write a pad byte at fill position
        logic       pad_80;      // pad byte is 0x80 (else zero)
        logic       put_len;     // write length into the last 8 bytes
        logic       load_digest; // latch chain as second message (32 bytes)
        logic       clear_fill;  // reset fill count after compression
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [6:0] fill;
        logic       round_last;
    } t_stat;

    localparam t_word InitWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadMark = 8'h80;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> src/sha_ctrl.sv
`default_nettype none
module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_hash_twice,
    input  wire logic  i_in_fire,
    input  wire logic  i_has_byte,
    input  wire logic  i_eom,
    input  wire logic  i_out_free,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_ready,
    output logic       o_out_load,
    output logic [2:0] o_out_idx
);

    t_state r_state, n_state;
    logic r_second, n_second;   // second pass of a double hash is running
    logic r_eom, n_eom;         // message close is pending
    logic r_padded, n_padded;   // 0x80 mark already written
    logic r_final, n_final;     // current compression is the length block
    logic [2:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_second <= 1'b0;
            r_eom    <= 1'b0;
            r_padded <= 1'b0;
            r_final  <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_eom    <= n_eom;
            r_padded <= n_padded;
            r_final  <= n_final;
            r_idx    <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_second   = r_second;
        n_eom      = r_eom;
        n_padded   = r_padded;
        n_final    = r_final;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_out_idx  = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.absorb = i_has_byte;
                    n_final = 1'b0;
                    n_eom   = i_eom;
                    if (i_has_byte && i_stat.fill == 7'd63) begin
                        n_state = ST_LOAD;
                    end else if (i_eom) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.start_comp = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_last) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.add_chain  = 1'b1;
                o_cmd.clear_fill = 1'b1;
                if (r_final) begin
                    n_state = ST_DIGEST;
                end else if (r_padded) begin
                    // padding spilled into a second block
                    n_state = ST_PADZ;
                end else if (r_eom) begin
                    n_state = ST_PAD80;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD80: begin
                o_cmd.pad_byte = 1'b1;
                o_cmd.pad_80   = 1'b1;
                n_padded = 1'b1;
                n_state  = ST_PADZ;
            end
            ST_PADZ: begin
                // zero fill up to the length field or to a full block
                if (i_stat.fill == 7'd56) begin
                    n_state = ST_PADLEN;
                end else if (i_stat.fill == 7'd64) begin
                    n_state = ST_LOAD;
                end else begin
                    o_cmd.pad_byte = 1'b1;
                end
            end
            ST_PADLEN: begin
                o_cmd.put_len = 1'b1;
                n_final  = 1'b1;
                n_padded = 1'b0;
                n_state  = ST_LOAD;
            end
            ST_DIGEST: begin
                n_final = 1'b0;
                if (i_hash_twice && !r_second) begin
                    o_cmd.load_digest = 1'b1;
                    n_second = 1'b1;
                    n_state  = ST_PAD80;
                end else begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.init_chain = 1'b1;
                        n_second = 1'b0;
                        n_eom    = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> src/sha_dpath.sv
`default_nettype none
module sha_dpath
    import sha_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [7:0] i_byte,
    input  wire logic [2:0] i_out_idx,
    output t_stat           o_stat,
    output t_word           o_digest_word
);

    t_word r_chain [8];
    t_word r_work [8];
    t_word r_win [16];
    t_word r_blk [16];          // block buffer, big-endian words
    logic [6:0] r_fill;
    logic [63:0] r_len;
    logic [5:0] r_round;

    // byte write port, shared by absorb and padding
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       wr_en;
    always_comb begin
        wr_addr = r_fill[5:0];
        wr_data = i_cmd.pad_80 ? PadMark : (i_cmd.absorb ? i_byte : 8'h00);
        wr_en   = i_cmd.absorb || i_cmd.pad_byte;
    end

    // message word for this round
    t_word w_in, w_sched, w_cur, s0w, s1w;
    t_word sg1, sg0, t1, t2, ch, maj;
    always_comb begin
        w_in = r_blk[r_round[3:0]];
        s1w = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        s0w = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        w_sched = s1w + r_win[9] + s0w + r_win[0];
        w_cur = (r_round < 6'd16) ? w_in : w_sched;
        sg1 = rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25);
        sg0 = rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22);
        ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
        maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
        t1 = r_work[7] + sg1 + ch + RoundK[r_round] + w_cur;
        t2 = sg0 + maj;
    end

    // block buffer: byte lane writes, length words, digest reload
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_blk[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
        end
        if (i_cmd.put_len) begin
            r_blk[14] <= r_len[63:32];
            r_blk[15] <= r_len[31:0];
        end
        if (i_cmd.load_digest) begin
            for (int j = 0; j < 8; j++) r_blk[j] <= r_chain[j];
        end
    end

    // counters and chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_len   <= '0;
            r_round <= '0;
            for (int j = 0; j < 8; j++) r_chain[j] <= InitWords[j];
        end else begin
            if (wr_en) r_fill <= r_fill + 7'd1;
            if (i_cmd.absorb) r_len <= r_len + 64'd8;
            if (i_cmd.clear_fill) r_fill <= '0;
            if (i_cmd.round) r_round <= r_round + 6'd1;
            if (i_cmd.add_chain) begin
                for (int j = 0; j < 8; j++) r_chain[j] <= r_chain[j] + r_work[j];
            end
            if (i_cmd.load_digest) begin
                // second message: 32 bytes, 256 bits
                r_fill <= 7'd32;
                r_len  <= 64'd256;
                for (int j = 0; j < 8; j++) r_chain[j] <= InitWords[j];
            end
            if (i_cmd.init_chain) begin
                r_fill <= '0;
                r_len  <= '0;
                for (int j = 0; j < 8; j++) r_chain[j] <= InitWords[j];
            end
        end
    end

    // working words and schedule window (shift register)
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_comp) begin
            for (int j = 0; j < 8; j++) r_work[j] <= r_chain[j];
        end
        if (i_cmd.round) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= t1 + t2;
            for (int j = 0; j < 15; j++) r_win[j] <= r_win[j + 1];
            r_win[15] <= w_cur;
        end
    end

    assign o_stat.fill       = r_fill;
    assign o_stat.round_last = (r_round == 6'(NumRounds - 1));
    assign o_digest_word     = r_chain[i_out_idx];

endmodule
`default_nettype wire

>>> src/sha256_stream_hasher_top.sv
// Channel  | Dir | tdata                         | tuser / tlast
// s_axis   | in  | [7:0] data_byte               | tuser has_byte, tlast end_of_message
// m_axis   | out | [31:0] digest_word            | tuser [2:0] word_index, tlast last_word
// cfg      | in  | i_cfg_wdata[0] hash_twice     | i_cfg_we
// One byte per cycle while a block fills; the 64th byte starts a compression
// (load, 64 rounds, chain add) before the next byte is taken.
// A close with n buffered bytes pads (n above 55 spills into a second block), compresses,
// then makes the digest decision. hash_twice adds padding of the digest, one more
// compression and one more decision; then eight words leave one per cycle while the
// output is free. Input is held off from a close until word 7 is loaded.
// Reset is synchronous, active low; the block buffer is not cleared. A stalled output
// holds the word; the controller waits for the output register to drain.
`default_nettype none
module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    logic  r_hash_twice;
    t_cmd  cmd;
    t_stat stat;
    logic  in_fire, out_load, out_free;
    logic [2:0] out_idx;
    t_word digest_word;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hash_twice <= 1'b0;
        else if (i_cfg_we) r_hash_twice <= i_cfg_wdata;
    end

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hash_twice (r_hash_twice),
        .i_in_fire    (in_fire),
        .i_has_byte   (s_axis_tuser),
        .i_eom        (s_axis_tlast),
        .i_out_free   (out_free),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_in_ready   (s_axis_tready),
        .o_out_load   (out_load),
        .o_out_idx    (out_idx)
    );

    sha_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_byte        (s_axis_tdata),
        .i_out_idx     (out_idx),
        .o_stat        (stat),
        .o_digest_word (digest_word)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (out_load) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            m_axis_tdata <= digest_word;
            m_axis_tuser <= out_idx;
            m_axis_tlast <= (out_idx == 3'd7);
        end
    end

endmodule
`default_nettype wire

>>> src/sha_port_chk.sv
`include "sha256_stream_hasher_top_assert.svh"
`default_nettype none
module sha_port_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // last word flag matches index seven
    `SHA_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 3'd7))
    // no input is taken while digest words other than the last are being shown
    `SHA_ASSERT_IMP(a_no_in_out, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
    // stalled word holds
    `SHA_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // word index steps by one between taken words
    `SHA_ASSERT_NXT(a_step, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid || m_axis_tuser == $past(m_axis_tuser) + 3'd1)

endmodule

bind sha256_stream_hasher_top sha_port_chk u_port_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
module testbench;
    import sha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_word;

    // Digest scoreboard: holds the SHA-256 model and the queue of expected words
    class digest_scoreboard;
        t_word         chain [8];
        logic [7:0]    block [64];
        int unsigned   fill;
        logic [63:0]   bit_len;
        bit            twice;
        t_digest_word  pending [$];
        int            errors;
        int            words_seen;
        int            messages;

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = InitWords[i];
            fill = 0;
            bit_len = '0;
        endfunction

        function t_word rr(t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            t_word w [64];
            t_word v [8];
            t_word s0, s1, t1, t2;
            for (int t = 0; t < 16; t++)
                w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
            for (int t = 16; t < 64; t++)
                w[t] = (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                     + (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int t = 0; t < 64; t++) begin
                s1 = rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25);
                s0 = rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22);
                t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
                t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void absorb(logic [7:0] b);
            block[fill] = b;
            fill++;
            bit_len += 64'd8;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        endfunction

        function void pad();
            int n;
            n = fill;
            block[n] = PadMark;
            n++;
            if (n > 56) begin
                while (n < 64) begin
                    block[n] = 8'h00;
                    n++;
                end
                compress();
                n = 0;
            end
            while (n < 56) begin
                block[n] = 8'h00;
                n++;
            end
            for (int j = 0; j < 8; j++) block[56+j] = bit_len[63-8*j -: 8];
            compress();
        endfunction

        function new();
            twice = 0;
            errors = 0;
            words_seen = 0;
            messages = 0;
            restart();
        endfunction

        // note one accepted input item
        function void note_input(logic [7:0] b, logic has_b, logic eom);
            t_word first [8];
            t_digest_word d;
            if (has_b) absorb(b);
            if (!eom) return;
            pad();
            if (twice) begin
                first = chain;
                restart();
                for (int j = 0; j < 32; j++) absorb(first[j/4][31-8*(j%4) -: 8]);
                pad();
            end
            for (int j = 0; j < 8; j++) begin
                d.word = chain[j];
                d.index = j[2:0];
                d.last = (j == 7);
                pending = {pending, d};
            end
            messages++;
            restart();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        // check one accepted output word
        task check_output(t_word word, logic [2:0] idx, logic last);
            t_digest_word d;
            words_seen++;
            if (pending.size() == 0) begin
                report("unexpected word", word, 32'd0);
                return;
            end
            d = pending.pop_front();
            if (word !== d.word) report("digest_word", word, d.word);
            if (idx !== d.index) report("word_index", 32'(idx), 32'(d.index));
            if (last !== d.last) report("last_word", 32'(last), 32'(d.last));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;   // [7:0] data_byte
    logic        s_axis_tuser = 0;   // [0] has_byte
    logic        s_axis_tlast = 0;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;       // [31:0] digest_word
    logic [2:0]  m_axis_tuser;       // [2:0] word_index
    logic        m_axis_tlast;       // last_word

    digest_scoreboard sb = new();
    int  idle_pct = 30;
    bit  hold_off = 0;
    int  quiet_cycles = 0;
    int  bytes_sent = 0;

    always #6 i_clk = ~i_clk;

    sha256_stream_hasher_top i_dut (.*);

    // monitor both handshakes and the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 4000) begin
                $display("watchdog: no progress");
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off
    always @(posedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // offer one item and wait until it is taken; valid stays up for the next call
    task automatic send(logic [7:0] b, logic has_b, logic eom);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= has_b;
        s_axis_tlast <= eom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (has_b) bytes_sent++;
    endtask

    task automatic send_message(int len, bit bare_end);
        for (int i = 0; i < len; i++)
            send(8'($urandom_range(255)), 1'b1, !bare_end && (i == len - 1));
        if (bare_end || len == 0) send(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_twice(bit v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.twice = v;
    endtask

    int len;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, idle items, byte extremes
        send(8'hff, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b1);
        send(8'h00, 1'b1, 1'b0);
        send(8'hff, 1'b1, 1'b0);
        send(8'h5a, 1'b0, 1'b0);
        send(8'ha5, 1'b1, 1'b1);
        drain();
        set_twice(1'b1);
        send(8'h00, 1'b0, 1'b1);
        send(8'h61, 1'b1, 1'b1);
        drain();
        set_twice(1'b0);

        // padding spilling into a second block, and a full block closed on its last byte
        send_message(63, 1);
        send_message(64, 0);
        drain();

        // random messages, the last three hashed twice; receiver held off from the third one on
        for (int m = 0; m < 12; m++) begin
            if (m == 4) idle_pct = 0;
            if (m == 7) idle_pct = 30;
            if (m == 9) begin
                drain();
                set_twice(1'b1);
            end
            if (m == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            len = $urandom_range(0, 4);
            if ($urandom_range(3) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0);
            send_message(len, 1'($urandom_range(1)));
        end
        drain();

        // back to back messages so the input backs up behind a held-off receiver
        set_twice(1'b1);
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge i_clk);
                hold_off = 0;
            end
        join_none
        send_message(2, 0);
        send_message(3, 1);
        drain();
        set_twice(1'b0);
        send_message(1, 0);
        drain();

        $display("covered %0d messages, %0d bytes, %0d digest words, both modes",
                 sb.messages, bytes_sent, sb.words_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

>>> sha256_stream_hasher_top.f
+incdir+src
src/sha_pkg.sv
src/sha_ctrl.sv
src/sha_dpath.sv
src/sha256_stream_hasher_top.sv
src/sha_port_chk.sv
tb/sv/testbench.sv
